>>> src/temporal_error_diffusion_dither_macros.svh
// assertion macros shared by the checker of the dither block
// each use expands to one labeled concurrent assertion on clk / rst_n
`ifndef TEMPORAL_ERROR_DIFFUSION_DITHER_MACROS_SVH
`define TEMPORAL_ERROR_DIFFUSION_DITHER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ted_pkg.sv
// shared types and constants of the temporal error diffusion dither block
// no dependencies; imported by every module of the block but ted_ram
`timescale 1ns / 1ps
`default_nettype none

package ted_pkg;

    // field widths
    localparam int IDX_W = 10;
    localparam int TGT_W = 16;
    localparam int LVL_W = 8;
    localparam int RES_W = 16;
    // target plus signed residual, with room for the rounding offset
    localparam int ACC_W = TGT_W + 2;

    // residual store, one entry per channel; the address is the low part of the index
    localparam int CHANNELS = 1024;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((IDX_W + TGT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + LVL_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAC      = 1'd1;

    // arithmetic constants
    localparam logic [ACC_W-1:0] HALF_STEP = ACC_W'(32'h0000_0080);
    localparam logic [LVL_W-1:0] LVL_MAX   = 8'hFF;

    typedef struct packed {
        logic             dither_enable;
        logic [LVL_W-1:0] frac_cutoff;
    } ted_cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [RES_W-1:0]  data;
    } ted_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ted_rd_t;

endpackage

`default_nettype wire

>>> src/ted_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ted_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/ted_clear.sv
// clearing sequencer: zeroes the residual store once after reset
// depends on ted_pkg
`timescale 1ns / 1ps
`default_nettype none

module ted_clear
    import ted_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    output ted_wr_t   wr,
    output logic      busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign wr.en   = busy_reg;
    assign wr.addr = cnt_reg;
    assign wr.data = '0;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

>>> src/ted_core.sv
// three-stage dither pipeline: residual fetch, accumulate, round and write back
// depends on ted_pkg; talks to the residual ram through ted_rd_t / ted_wr_t
`timescale 1ns / 1ps
`default_nettype none

module ted_core
    import ted_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ted_cfg_t             cfg,
    input  wire logic                 clearing,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output ted_rd_t                   rd,
    input  wire logic [RES_W-1:0]     rd_data,
    output ted_wr_t                   wr
);

    // stage 1: fields, residual read in flight
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic [TGT_W-1:0] p1_tgt_reg;
    logic             p1_trunc_reg;
    logic             p1_inrange_reg;
    // stage 2: accumulated value
    logic             p2_valid_reg;
    logic [IDX_W-1:0] p2_idx_reg;
    logic [ACC_W-1:0] p2_acc_reg;
    logic [LVL_W-1:0] p2_tgt_hi_reg;
    logic             p2_trunc_reg;
    logic             p2_inrange_reg;
    // stage 3: result register, residual kept for forwarding
    logic             p3_valid_reg;
    logic [IDX_W-1:0] p3_idx_reg;
    logic [LVL_W-1:0] p3_lvl_reg;
    logic [RES_W-1:0] p3_res_reg;
    logic             p3_inrange_reg;

    logic             en1;
    logic             en2;
    logic             en3;
    logic             accept;
    logic [IDX_W-1:0] in_idx;
    logic [TGT_W-1:0] in_tgt;
    logic [LVL_W-1:0] in_frac;
    logic             in_trunc;
    logic             in_inrange;
    logic             p2_hit;
    logic             p3_hit;
    logic [RES_W-1:0] res_fwd;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] rnd;
    logic [ACC_W-1:0] diff;
    logic [LVL_W-1:0] q_lvl;
    logic [RES_W-1:0] q_res;

    // each stage loads when empty or when the stage after it moves
    assign en3      = !p3_valid_reg || m_tready;
    assign en2      = !p2_valid_reg || en3;
    assign en1      = !p1_valid_reg || en2;
    assign s_tready = en1 && !clearing;
    assign accept   = s_tvalid && s_tready;

    assign in_idx     = s_tdata[IDX_W-1:0];
    assign in_tgt     = s_tdata[IDX_W +: TGT_W];
    assign in_frac    = in_tgt[LVL_W-1:0];
    assign in_inrange = 32'(in_idx) < 32'(CHANNELS);
    assign in_trunc   = !cfg.dither_enable || s_tuser
                        || ((in_frac != '0) && (in_frac < cfg.frac_cutoff));

    assign rd.en   = accept;
    assign rd.addr = in_idx[ADDR_W-1:0];

    // newer residuals that the ram read did not see yet: the item being written
    // this cycle wins over the one written on the previous move
    assign p2_hit = p2_valid_reg && p2_inrange_reg && (p2_idx_reg == p1_idx_reg);
    assign p3_hit = p3_valid_reg && p3_inrange_reg && (p3_idx_reg == p1_idx_reg);

    always_comb
    begin
        if (!p1_inrange_reg)
        begin
            res_fwd = '0;
        end
        else if (p2_hit)
        begin
            res_fwd = q_res;
        end
        else if (p3_hit)
        begin
            res_fwd = p3_res_reg;
        end
        else
        begin
            res_fwd = rd_data;
        end
    end

    assign acc_next = {{(ACC_W - TGT_W){1'b0}}, p1_tgt_reg}
                      + {{(ACC_W - RES_W){res_fwd[RES_W-1]}}, res_fwd};

    // round by half a step, clamp to the 16-bit range, keep the error
    assign rnd  = p2_acc_reg + HALF_STEP;
    assign diff = p2_acc_reg - {{(ACC_W - 2 * LVL_W){1'b0}}, q_lvl, q_lvl};

    always_comb
    begin
        if (p2_trunc_reg)
        begin
            q_lvl = p2_tgt_hi_reg;
            q_res = '0;
        end
        else
        begin
            if (rnd[ACC_W-1])
            begin
                q_lvl = '0;
            end
            else if (rnd[ACC_W-2:TGT_W] != '0)
            begin
                q_lvl = LVL_MAX;
            end
            else
            begin
                q_lvl = rnd[TGT_W-1:LVL_W];
            end
            q_res = diff[RES_W-1:0];
        end
    end

    assign wr.en   = en2 && p2_valid_reg && p2_inrange_reg;
    assign wr.addr = p2_idx_reg[ADDR_W-1:0];
    assign wr.data = q_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                p1_valid_reg <= accept;
            end
            if (en2)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (en3)
            begin
                p3_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_idx_reg     <= in_idx;
            p1_tgt_reg     <= in_tgt;
            p1_trunc_reg   <= in_trunc;
            p1_inrange_reg <= in_inrange;
        end
        if (en2 && p1_valid_reg)
        begin
            p2_idx_reg     <= p1_idx_reg;
            p2_acc_reg     <= acc_next;
            p2_tgt_hi_reg  <= p1_tgt_reg[TGT_W-1:LVL_W];
            p2_trunc_reg   <= p1_trunc_reg;
            p2_inrange_reg <= p1_inrange_reg;
        end
        if (en3 && p2_valid_reg)
        begin
            p3_idx_reg     <= p2_idx_reg;
            p3_lvl_reg     <= q_lvl;
            p3_res_reg     <= q_res;
            p3_inrange_reg <= p2_inrange_reg;
        end
    end

    assign m_tvalid = p3_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - LVL_W){1'b0}}, p3_lvl_reg, p3_idx_reg};

endmodule

`default_nettype wire

>>> src/temporal_error_diffusion_dither.sv
// Temporal error-diffusion dither, 16-bit channel target in, 8-bit LED level out.
// One transfer per clock is taken unless back-pressure or clearing stalls it; one
// result per transfer comes out of the stage 3 register, in order; that rate holds
// even when the same channel arrives on consecutive cycles, as the newest residual
// is forwarded from the write-back stage. The clock is set by the residual loop
// (add residual, round and clamp, subtract level*257) that closes through the
// stage 2 register. Residuals live in a 1024 x 16 ram; after reset a clearing pass
// over all CHANNELS (1024) entries zeroes it and s_tready stays low meanwhile,
// while register writes are taken as usual. Register writes must only happen while
// no transfer is in flight. Depends on ted_pkg, ted_ram, ted_clear and ted_core.
`timescale 1ns / 1ps
`default_nettype none

module temporal_error_diffusion_dither
    import ted_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // channel_index[9:0], target[25:10]
    input  wire logic                  s_tuser,   // static_frame
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata    // out_index[9:0], level[17:10]
);

    ted_cfg_t         cfg_reg;
    ted_cfg_t         cfg_next;
    ted_wr_t          clr_wr;
    ted_wr_t          core_wr;
    ted_wr_t          ram_wr;
    ted_rd_t          core_rd;
    logic             clearing;
    logic [RES_W-1:0] ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DITHER_ENABLE: cfg_next.dither_enable = cfg_data[0];
                REG_MIN_FRAC:      cfg_next.frac_cutoff   = cfg_data[LVL_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dither_enable <= 1'b1;
            cfg_reg.frac_cutoff   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ted_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (clr_wr),
        .busy  (clearing)
    );

    // the clearing pass owns the write port until it is done
    assign ram_wr = clearing ? clr_wr : core_wr;

    ted_ram #(
        .WIDTH (RES_W),
        .DEPTH (CHANNELS)
    ) u_res_ram (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (core_rd.en),
        .raddr (core_rd.addr),
        .rdata (ram_rdata)
    );

    ted_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .rd       (core_rd),
        .rd_data  (ram_rdata),
        .wr       (core_wr)
    );

endmodule

`default_nettype wire

>>> src/ted_checker.sv
// port-level checker for the dither block, bound to the top level
// depends on ted_pkg and temporal_error_diffusion_dither_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "temporal_error_diffusion_dither_macros.svh"

module ted_checker
    import ted_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // transfers taken but not yet delivered
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // the residual store is being cleared right after reset
    `TED_ASSERT_NOW(a_no_take_after_reset, !$past(rst_n), !s_tready, "transfer taken during clear")
    // three stages hold at most three items
    `TED_ASSERT_NOW(a_inflight_bound, 1'b1, inflight_reg <= 3'd3, "more than three items in flight")
    `TED_ASSERT_NOW(a_full_stalls, (inflight_reg == 3'd3) && !m_tready, !s_tready,
                    "transfer taken into a full pipeline")
    `TED_ASSERT_NOW(a_no_phantom, m_tvalid, inflight_reg != 3'd0, "result without a transfer")
    `TED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                     "stalled result changed")

endmodule

bind temporal_error_diffusion_dither ted_checker u_ted_checker (.*);

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for temporal_error_diffusion_dither
// a clocked driver feeds transfers and register writes from a queue, and a clocked monitor
// checks each level against a per-channel residual predictor; depends on ted_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import ted_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 5;
    localparam int TAIL_CYCLES   = 8;

    typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_PAUSE} op_kind_t;

    typedef struct {
        op_kind_t             kind;
        logic [IDX_W-1:0]     ch;
        logic [TGT_W-1:0]     tgt;
        logic                 stat;
        int                   gap;
        logic [CFG_IDX_W-1:0] regsel;
        logic [CFG_DATA_W-1:0] val;
    } op_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] lvl;
    } level_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    temporal_error_diffusion_dither uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: register copies and the signed residual per channel
    logic                    model_enable = 1'b1;
    logic [LVL_W-1:0]        model_cutoff = '0;
    logic signed [RES_W-1:0] chan_residual [CHANNELS];

    op_t        pending_ops [$];
    level_rec_t levels_due [$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int writes_done = 0;
    int pauses_done = 0;
    int n_trunc = 0;
    int n_clamp_hi = 0;
    int n_clamp_lo = 0;
    int send_calm = 0;
    int cycles = 0;

    initial
    begin
        for (int k = 0; k < CHANNELS; k++)
            chan_residual[k] = '0;
    end

    function automatic logic [LVL_W-1:0] dither_level(input logic [IDX_W-1:0] ch,
                                                      input logic [TGT_W-1:0] tgt,
                                                      input logic stat);
        logic [7:0] frac;
        int acc;
        int sum;
        int lvl;
        frac = tgt[7:0];
        if (!model_enable || stat || (frac != 8'd0 && frac < model_cutoff))
        begin
            lvl = int'(tgt[15:8]);
            chan_residual[ch] = '0;
            n_trunc++;
        end
        else
        begin
            acc = int'(tgt) + int'(chan_residual[ch]);
            sum = acc + 128;
            if (sum < 0)
            begin
                sum = 0;
                n_clamp_lo++;
            end
            else if (sum > 65535)
            begin
                sum = 65535;
                n_clamp_hi++;
            end
            lvl = sum / 256;
            // residual keeps the unclamped error
            chan_residual[ch] = RES_W'(acc - lvl * 257);
        end
        return lvl[LVL_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // sender gap, with stretches of back-to-back transfers
    function automatic int draw_gap();
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            send_calm = $urandom_range(8, 40);
        return $urandom_range(0, 6);
    endfunction

    task automatic queue_sample(input logic [IDX_W-1:0] ch, input logic [TGT_W-1:0] tgt,
                                input logic stat, input int gap);
        op_t op;
        op = '{kind: OP_SAMPLE, ch: ch, tgt: tgt, stat: stat, gap: gap, regsel: '0, val: '0};
        pending_ops.push_back(op);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] regsel,
                               input logic [CFG_DATA_W-1:0] val);
        op_t op;
        op = '{kind: OP_WRITE, ch: '0, tgt: '0, stat: 1'b0, gap: 0, regsel: regsel, val: val};
        pending_ops.push_back(op);
    endtask

    task automatic queue_pause();
        op_t op;
        op = '{kind: OP_PAUSE, ch: '0, tgt: '0, stat: 1'b0, gap: 0, regsel: '0, val: '0};
        pending_ops.push_back(op);
    endtask

    // driver
    op_t  drv_cur;
    op_t  drv_head;
    logic drv_valid;
    logic drv_we;
    int   drv_hold = 0;
    int   drv_quiet = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            drv_valid = s_tvalid;
            drv_we = 1'b0;
            if (s_tvalid && s_tready)
            begin
                levels_due.push_back('{idx: drv_cur.ch,
                                       lvl: dither_level(drv_cur.ch, drv_cur.tgt, drv_cur.stat)});
                items_sent++;
                drv_valid = 1'b0;
            end
            // results_seen still holds its value from before this edge
            if (!drv_valid && items_sent == results_seen)
                drv_quiet++;
            else
                drv_quiet = 0;
            if (!drv_valid)
            begin
                if (drv_hold > 0)
                    drv_hold--;
                else if (pending_ops.size() > 0)
                begin
                    drv_head = pending_ops[0];
                    case (drv_head.kind)
                        OP_SAMPLE:
                        begin
                            if (drv_head.gap > 0)
                            begin
                                drv_hold = drv_head.gap - 1;
                                pending_ops[0].gap = 0;
                            end
                            else
                            begin
                                void'(pending_ops.pop_front());
                                drv_cur = drv_head;
                                drv_valid = 1'b1;
                                s_tdata <= {{(S_TDATA_W - IDX_W - TGT_W){1'b0}},
                                            drv_head.tgt, drv_head.ch};
                                s_tuser <= drv_head.stat;
                            end
                        end
                        OP_WRITE:
                        begin
                            // registers change only with nothing in flight
                            if (drv_quiet >= SETTLE_CYCLES)
                            begin
                                void'(pending_ops.pop_front());
                                drv_we = 1'b1;
                                cfg_index <= drv_head.regsel;
                                cfg_data <= drv_head.val;
                                if (drv_head.regsel == REG_DITHER_ENABLE)
                                    model_enable = drv_head.val[0];
                                else if (drv_head.regsel == REG_MIN_FRAC)
                                    model_cutoff = drv_head.val[LVL_W-1:0];
                                writes_done++;
                                drv_quiet = 0;
                            end
                        end
                        OP_PAUSE:
                        begin
                            if (drv_quiet >= SETTLE_CYCLES)
                            begin
                                void'(pending_ops.pop_front());
                                pauses_done++;
                            end
                        end
                        default:
                            void'(pending_ops.pop_front());
                    endcase
                end
            end
            s_tvalid <= drv_valid;
            cfg_we <= drv_we;
        end
    end

    // monitor
    level_rec_t mon_exp;
    logic [IDX_W-1:0] mon_idx;
    logic [LVL_W-1:0] mon_lvl;
    logic mon_ready;
    int   mon_stall = 0;
    int   mon_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            mon_ready = m_tready;
            if (m_tvalid && m_tready)
            begin
                mon_idx = m_tdata[IDX_W-1:0];
                mon_lvl = m_tdata[IDX_W +: LVL_W];
                if (levels_due.size() == 0)
                    report_mismatch($sformatf("unexpected transfer idx=%0d level=%0d",
                                              mon_idx, mon_lvl));
                else
                begin
                    mon_exp = levels_due.pop_front();
                    if (mon_idx !== mon_exp.idx)
                        report_mismatch($sformatf("out_index %0d, expected %0d",
                                                  mon_idx, mon_exp.idx));
                    if (mon_lvl !== mon_exp.lvl)
                        report_mismatch($sformatf("level %0d, expected %0d on channel %0d",
                                                  mon_lvl, mon_exp.lvl, mon_exp.idx));
                end
                results_seen <= results_seen + 1;
                if (mon_calm > 0)
                begin
                    mon_calm--;
                    mon_stall = 0;
                end
                else
                begin
                    mon_stall = $urandom_range(0, 6);
                    if ($urandom_range(0, 15) == 0)
                        mon_calm = $urandom_range(8, 40);
                end
                mon_ready = (mon_stall == 0);
            end
            else if (!m_tready)
            begin
                if (mon_stall > 0)
                    mon_stall--;
                mon_ready = (mon_stall == 0);
            end
            m_tready <= mon_ready;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    logic [IDX_W-1:0] hot_ch [8];
    logic             phase_en [8];
    logic [7:0]       phase_min [8];

    initial
    begin
        int p;
        int i;
        int f;
        int sel;
        logic [7:0] mf;
        logic [IDX_W-1:0] ch;
        logic [TGT_W-1:0] tgt;

        // directed: extremes, clamping, forwarding, static frames, cutoff edges
        queue_write(REG_DITHER_ENABLE, 8'd1);
        queue_write(REG_MIN_FRAC, 8'd0);
        queue_sample(10'd0, 16'h0000, 1'b0, 0);
        queue_sample(10'd1023, 16'hFFFF, 1'b0, 0);
        queue_sample(10'd1023, 16'hFFFF, 1'b0, 0);
        queue_sample(10'h2AA, 16'hAAAA, 1'b0, 1);
        queue_sample(10'h155, 16'h5555, 1'b0, 0);
        // negative residual then zero target clamps low
        queue_sample(10'd5, 16'h0080, 1'b0, 0);
        queue_sample(10'd5, 16'h0000, 1'b0, 0);
        queue_sample(10'd5, 16'h0000, 1'b0, 3);
        queue_sample(10'd6, 16'h00FF, 1'b0, 0);
        queue_sample(10'd6, 16'h00FF, 1'b0, 0);
        queue_sample(10'd6, 16'h00FF, 1'b0, 0);
        queue_sample(10'd6, 16'h1234, 1'b1, 0);
        queue_sample(10'd6, 16'h1234, 1'b0, 0);
        queue_sample(10'd7, 16'h1200, 1'b0, 2);
        queue_write(REG_MIN_FRAC, 8'h40);
        queue_sample(10'd8, 16'h1010, 1'b0, 0);
        queue_sample(10'd8, 16'h1000, 1'b0, 0);
        queue_sample(10'd8, 16'h1040, 1'b0, 0);
        queue_sample(10'd8, 16'h103F, 1'b0, 0);
        queue_sample(10'd9, 16'h10C0, 1'b1, 0);
        queue_write(REG_DITHER_ENABLE, 8'd0);
        queue_sample(10'd9, 16'h10C0, 1'b0, 0);
        queue_sample(10'd9, 16'hFFFF, 1'b0, 0);
        queue_write(REG_DITHER_ENABLE, 8'd1);
        queue_write(REG_MIN_FRAC, 8'hFF);
        queue_sample(10'd11, 16'h20FE, 1'b0, 0);
        queue_sample(10'd11, 16'h20FF, 1'b0, 0);
        queue_sample(10'd11, 16'h20FF, 1'b0, 0);

        // random: a few busy channels carry residuals across frames
        hot_ch[0] = 10'd0;
        hot_ch[1] = 10'd1023;
        for (i = 2; i < 8; i++)
            hot_ch[i] = IDX_W'($urandom);
        phase_en = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_min = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd255, 8'd128, 8'd0};
        for (p = 0; p < 8; p++)
        begin
            mf = (p == 4 || p == 7) ? 8'($urandom_range(1, 254)) : phase_min[p];
            queue_write(REG_DITHER_ENABLE, {7'd0, phase_en[p]});
            queue_write(REG_MIN_FRAC, mf);
            for (i = 0; i < 50; i++)
            begin
                if (i == 25 && (p % 3) == 1)
                    queue_pause();
                ch = ($urandom_range(0, 9) < 7) ? hot_ch[$urandom_range(0, 7)]
                                                : IDX_W'($urandom);
                tgt = TGT_W'($urandom);
                sel = $urandom_range(0, 9);
                if (sel < 2)
                begin
                    // fractions around the cutoff
                    f = int'(mf) + int'($urandom_range(0, 3)) - 2;
                    if (f < 0)
                        f = 0;
                    if (f > 255)
                        f = 255;
                    tgt[7:0] = 8'(f);
                end
                else if (sel == 2)
                    tgt[7:0] = 8'h00;
                else if (sel == 3)
                    tgt[15:8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                queue_sample(ch, tgt, $urandom_range(0, 11) == 0, draw_gap());
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || items_sent != results_seen)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (levels_due.size() != 0)
            report_mismatch($sformatf("%0d levels never arrived", levels_due.size()));

        $display("covered %0d transfers, %0d register writes, %0d drain pauses",
                 items_sent, writes_done, pauses_done);
        $display("levels: %0d truncated, %0d clamped high, %0d clamped low",
                 n_trunc, n_clamp_hi, n_clamp_lo);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
